[design/ascii_integer_parser_unit_defines.svh]
// Assertion helpers used by the checker file.
`ifndef ASCII_INTEGER_PARSER_UNIT_DEFINES_SVH
`define ASCII_INTEGER_PARSER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define AIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AIP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/aip_pkg.sv]
package aip_pkg;

    localparam int VALUE_W = 64;

    // number base of the digits that follow
    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_HEX = 2'd1;
    localparam logic [1:0] RX_BIN = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
    localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
    localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
    localparam logic [7:0] CH_UB    = 8'h42;  // 'B'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef struct packed {
        logic [1:0] width_select;
        logic       signed_mode;
    } aip_cfg_t;

    typedef struct packed {
        logic       digit_ok;
        logic [3:0] digit;
        logic       is_zero;
        logic       is_minus;
        logic       is_x;
        logic       is_b;
    } aip_char_t;

endpackage

[design/aip_char_decode.sv]
module aip_char_decode
    import aip_pkg::*;
(
    input  logic [7:0] char_code,
    input  logic [1:0] radix,
    output aip_char_t  info
);

    logic       is_num;
    logic       is_lo;
    logic       is_up;
    logic [7:0] raw;

    always_comb begin
        is_num = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_lo  = (char_code >= CH_LA) && (char_code <= CH_LF);
        is_up  = (char_code >= CH_UA) && (char_code <= CH_UF);
        raw    = 8'd0;
        if (is_num) begin
            raw = char_code - CH_ZERO;
        end else if (is_lo) begin
            raw = char_code - CH_LA + 8'd10;
        end else if (is_up) begin
            raw = char_code - CH_UA + 8'd10;
        end
        info.digit = raw[3:0];
        unique case (radix)
            RX_HEX:  info.digit_ok = is_num || is_lo || is_up;
            RX_BIN:  info.digit_ok = is_num && (raw[3:0] < 4'd2);
            default: info.digit_ok = is_num;
        endcase
        info.is_zero  = (char_code == CH_ZERO);
        info.is_minus = (char_code == CH_MINUS);
        info.is_x     = (char_code == CH_LX) || (char_code == CH_UX);
        info.is_b     = (char_code == CH_LB) || (char_code == CH_UB);
    end

endmodule

[design/aip_string_state.sv]
module aip_string_state
    import aip_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic               action,
    input  logic [7:0]         char_code,
    input  aip_cfg_t           cfg,
    output logic               res_ok,
    output logic [VALUE_W-1:0] res_value
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    localparam logic [1:0] WS_8  = 2'd0;
    localparam logic [1:0] WS_16 = 2'd1;
    localparam logic [1:0] WS_32 = 2'd2;

    localparam int PROD_W = VALUE_W + 5;

    logic [2:0]         phase_reg, phase_next;
    logic [1:0]         radix_reg, radix_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    logic               syn_reg, syn_next;
    logic               seen_reg, seen_next;

    logic [1:0]         eff_radix;
    aip_char_t          info;
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] half;
    logic [PROD_W-1:0]  acc_ext;
    logic [PROD_W-1:0]  prod;
    logic               prod_ovf;

    // the first character of the unsigned part always starts a decimal number
    assign eff_radix = ((phase_reg == PH_START) || (phase_reg == PH_SIGN)) ? RX_DEC
                                                                           : radix_reg;

    aip_char_decode u_dec (
        .char_code (char_code),
        .radix     (eff_radix),
        .info      (info)
    );

    always_comb begin
        unique case (cfg.width_select)
            WS_8:    mask = {{(VALUE_W-8){1'b0}}, {8{1'b1}}};
            WS_16:   mask = {{(VALUE_W-16){1'b0}}, {16{1'b1}}};
            WS_32:   mask = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};
            default: mask = {VALUE_W{1'b1}};
        endcase
        half = (mask >> 1) + {{(VALUE_W-1){1'b0}}, 1'b1};
    end

    // acc * radix + digit by shifts, kept wide enough to never wrap
    always_comb begin
        acc_ext = {5'd0, acc_reg};
        unique case (eff_radix)
            RX_HEX:  prod = acc_ext << 4;
            RX_BIN:  prod = acc_ext << 1;
            default: prod = (acc_ext << 3) + (acc_ext << 1);
        endcase
        prod     = prod + {{(PROD_W-4){1'b0}}, info.digit};
        prod_ovf = prod > {5'd0, mask};
    end

    always_comb begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        syn_next   = syn_reg;
        seen_next  = seen_reg;
        if (action == ACT_END) begin
            phase_next = PH_START;
            radix_next = RX_DEC;
            acc_next   = '0;
            neg_next   = 1'b0;
            ovf_next   = 1'b0;
            syn_next   = 1'b0;
            seen_next  = 1'b0;
        end else if (!syn_reg) begin
            if ((phase_reg == PH_START) && info.is_minus && cfg.signed_mode) begin
                neg_next   = 1'b1;
                phase_next = PH_SIGN;
            end else if ((phase_reg == PH_START || phase_reg == PH_SIGN) && info.is_zero) begin
                radix_next = RX_DEC;
                acc_next   = '0;
                seen_next  = 1'b1;
                phase_next = PH_ZERO;
            end else if ((phase_reg == PH_ZERO) && (info.is_x || info.is_b)) begin
                radix_next = info.is_x ? RX_HEX : RX_BIN;
                seen_next  = 1'b0;
                phase_next = PH_PREFIX;
            end else begin
                radix_next = eff_radix;
                if (!info.digit_ok) begin
                    syn_next = 1'b1;
                end else begin
                    if (prod_ovf) begin
                        ovf_next = 1'b1;
                        acc_next = prod[VALUE_W-1:0] & mask;
                    end else begin
                        acc_next = prod[VALUE_W-1:0];
                    end
                    seen_next  = 1'b1;
                    phase_next = PH_DIGITS;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            radix_reg <= RX_DEC;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            syn_reg   <= 1'b0;
            seen_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            syn_reg   <= syn_next;
            seen_reg  <= seen_next;
        end
    end

    // end-of-string verdict from the current state
    always_comb begin
        logic               ok;
        logic [VALUE_W-1:0] val;
        ok  = !syn_reg && seen_reg && !ovf_reg && (acc_reg <= mask);
        val = acc_reg;
        if (ok) begin
            if (cfg.signed_mode) begin
                if (neg_reg) begin
                    ok  = (acc_reg != '0) && (acc_reg <= half);
                    val = '0 - acc_reg;
                end else begin
                    ok = acc_reg < half;
                end
            end else begin
                ok = !neg_reg;
            end
        end
        res_ok    = ok;
        res_value = ok ? val : '0;
    end

endmodule

[design/ascii_integer_parser_unit.sv]
// ASCII integer parser.
// Input channel (s_valid/s_ready): one transaction per character with
// s_action = 0 and the byte on s_char_code, then one with s_action = 1 to
// close the string. Output channel (m_valid/m_ready): one transaction per
// closed string, m_ok and m_value (zero when m_ok is 0, sign-extended in
// signed mode). Optional '-' in signed mode, "0x"/"0b" prefixes select base.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 = width_select, 1 = signed_mode); write only while the block is idle.
// Throughput: one transaction per cycle on the input while no end transaction
// waits on a full result register, set by the shift-add-compare loop on the
// accumulator. An accepted end transaction passes through the input register
// into the result register, which drives m_valid.
// Reset (aresetn low, synchronous) empties both registers, clears the
// string state, width_select = 64 bits, signed_mode = 0.
// When the receiver stalls, characters keep flowing; an end transaction that
// meets a full result register waits in the input register, and s_ready stays
// low until the receiver takes the pending result.
module ascii_integer_parser_unit
    import aip_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [7:0]         s_char_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic [VALUE_W-1:0] m_value
);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    aip_cfg_t           cfg_reg;
    logic               in_vld_reg;
    logic               in_action_reg;
    logic [7:0]         in_char_reg;
    logic               out_vld_reg;
    logic               out_ok_reg;
    logic [VALUE_W-1:0] out_value_reg;

    logic               out_free;
    logic               advance;
    logic               res_ok;
    logic [VALUE_W-1:0] res_value;

    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && ((in_action_reg == ACT_CHAR) || out_free);
    assign s_ready  = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width_select <= 2'd3;
            cfg_reg.signed_mode  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  cfg_reg.width_select <= cfg_wdata;
                REG_SIGNED: cfg_reg.signed_mode  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_action_reg <= s_action;
            in_char_reg   <= s_char_code;
        end
    end

    aip_string_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .action    (in_action_reg),
        .char_code (in_char_reg),
        .cfg       (cfg_reg),
        .res_ok    (res_ok),
        .res_value (res_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= advance && (in_action_reg == ACT_END);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && (in_action_reg == ACT_END)) begin
            out_ok_reg    <= res_ok;
            out_value_reg <= res_value;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_ok    = out_ok_reg;
    assign m_value = out_value_reg;

endmodule

[design/aip_checker.sv]
`include "ascii_integer_parser_unit_defines.svh"

module aip_checker
    import aip_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_ok,
    input logic [VALUE_W-1:0] m_value
);

    `AIP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_value), "result changed while stalled")

    `AIP_ASSERT(a_fail_zero, m_valid && !m_ok |-> m_value == '0, "failed result carries a value")

    `AIP_ASSERT(a_no_stall, m_ready |-> s_ready, "input stalled while receiver is ready")

    `AIP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind ascii_integer_parser_unit aip_checker u_aip_checker (.*);
